// ===== src/fan_light_relay_interlock_top_defines.svh =====
// Assertion macros for the fan and light relay interlock.
`ifndef FAN_LIGHT_RELAY_INTERLOCK_TOP_DEFINES_SVH
`define FAN_LIGHT_RELAY_INTERLOCK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLRI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FLRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/flri_pkg.sv =====
package flri_pkg;

    localparam int TICK_W     = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_COMMAND   = 3'd1;
    localparam logic [2:0] FUNC_LIGHT_BTN = 3'd2;
    localparam logic [2:0] FUNC_FAN_BTN   = 3'd3;
    localparam logic [2:0] FUNC_SPEED_BTN = 3'd4;

    localparam logic [1:0] SPEED_MIN     = 2'd0;
    localparam logic [1:0] SPEED_MID     = 2'd1;
    localparam logic [1:0] SPEED_MAX     = 2'd2;
    localparam logic [1:0] SPEED_NOT_SET = 2'd3;

    localparam logic [1:0] REG_DIRECTION_INVERT      = 2'd0;
    localparam logic [1:0] REG_BUTTONS_ENABLED       = 2'd1;
    localparam logic [1:0] REG_FAN_LOCKOUT_TICKS     = 2'd2;
    localparam logic [1:0] REG_REVERSE_LOCKOUT_TICKS = 2'd3;

    localparam logic [TICK_W-1:0] FAN_LOCKOUT_RESET     = 16'd3000;
    localparam logic [TICK_W-1:0] REVERSE_LOCKOUT_RESET = 16'd30000;

    typedef struct packed {
        logic [2:0] func;
        logic       set_light;
        logic       light_value;
        logic       set_direction;
        logic       direction_up;
        logic       set_fan;
        logic       fan_value;
        logic [1:0] speed_request;
    } cmd_word_t;

    typedef struct packed {
        logic       light_on;
        logic       fan_on;
        logic       direction_state;
        logic [1:0] speed_now;
        logic       light_pin;
        logic       fan_pin;
        logic       direction_pin;
        logic       speed_mid_pin;
        logic       speed_max_pin;
        logic       fan_locked;
        logic       reverse_locked;
    } res_word_t;

    typedef struct packed {
        logic              direction_invert;
        logic              buttons_enabled;
        logic [TICK_W-1:0] fan_lockout_ticks;
        logic [TICK_W-1:0] reverse_lockout_ticks;
    } cfg_t;

endpackage

// ===== src/flri_cfg_regs.sv =====
module flri_cfg_regs
    import flri_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_invert      <= 1'b0;
            cfg_reg.buttons_enabled       <= 1'b1;
            cfg_reg.fan_lockout_ticks     <= FAN_LOCKOUT_RESET;
            cfg_reg.reverse_lockout_ticks <= REVERSE_LOCKOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_DIRECTION_INVERT:      cfg_reg.direction_invert      <= pwdata[0];
                REG_BUTTONS_ENABLED:       cfg_reg.buttons_enabled       <= pwdata[0];
                REG_FAN_LOCKOUT_TICKS:     cfg_reg.fan_lockout_ticks     <= pwdata[TICK_W-1:0];
                REG_REVERSE_LOCKOUT_TICKS: cfg_reg.reverse_lockout_ticks <= pwdata[TICK_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DIRECTION_INVERT:
                prdata = APB_DATA_W'(cfg_reg.direction_invert);
            REG_BUTTONS_ENABLED:
                prdata = APB_DATA_W'(cfg_reg.buttons_enabled);
            REG_FAN_LOCKOUT_TICKS:
                prdata = APB_DATA_W'(cfg_reg.fan_lockout_ticks);
            REG_REVERSE_LOCKOUT_TICKS:
                prdata = APB_DATA_W'(cfg_reg.reverse_lockout_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== src/flri_core.sv =====
module flri_core
    import flri_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cfg_t      cfg,
    input  cmd_word_t word,
    output res_word_t result
);

    logic                   light_reg, light_next;
    logic                   fan_reg, fan_next;
    logic                   direction_reg, direction_next;
    logic [1:0]             speed_reg, speed_next;
    logic [COUNT_WIDTH-1:0] fan_cnt_reg, fan_cnt_next;
    logic [COUNT_WIDTH-1:0] rev_cnt_reg, rev_cnt_next;
    logic [COUNT_WIDTH-1:0] fan_reload, rev_reload;

    logic       is_tick, is_cmd, light_btn, fan_btn, speed_btn;
    logic       speed_req_ok, fan_req_ok, fan_req_val;
    logic [1:0] speed_req_val, speed_step;

    // saturate reload values into the counter width
    generate
        if (COUNT_WIDTH >= TICK_W)
        begin : g_wide
            assign fan_reload = COUNT_WIDTH'(cfg.fan_lockout_ticks);
            assign rev_reload = COUNT_WIDTH'(cfg.reverse_lockout_ticks);
        end
        else
        begin : g_narrow
            assign fan_reload = (|cfg.fan_lockout_ticks[TICK_W-1:COUNT_WIDTH]) ?
                                '1 : cfg.fan_lockout_ticks[COUNT_WIDTH-1:0];
            assign rev_reload = (|cfg.reverse_lockout_ticks[TICK_W-1:COUNT_WIDTH]) ?
                                '1 : cfg.reverse_lockout_ticks[COUNT_WIDTH-1:0];
        end
    endgenerate

    assign is_tick   = (word.func == FUNC_TICK);
    assign is_cmd    = (word.func == FUNC_COMMAND);
    assign light_btn = cfg.buttons_enabled && (word.func == FUNC_LIGHT_BTN);
    assign fan_btn   = cfg.buttons_enabled && (word.func == FUNC_FAN_BTN);
    assign speed_btn = cfg.buttons_enabled && (word.func == FUNC_SPEED_BTN);

    assign speed_step    = (speed_reg == SPEED_MAX) ? SPEED_MIN : speed_reg + 2'd1;
    assign speed_req_ok  = is_cmd || speed_btn;
    assign speed_req_val = is_cmd ? word.speed_request : speed_step;
    assign fan_req_ok    = (is_cmd && word.set_fan) || fan_btn;
    assign fan_req_val   = is_cmd ? word.fan_value : !fan_reg;

    always_comb
    begin
        light_next     = light_reg;
        fan_next       = fan_reg;
        direction_next = direction_reg;
        speed_next     = speed_reg;
        fan_cnt_next   = fan_cnt_reg;
        rev_cnt_next   = rev_cnt_reg;

        if (is_tick)
        begin
            if (fan_cnt_reg != '0)
                fan_cnt_next = fan_cnt_reg - COUNT_WIDTH'(1);
            if (rev_cnt_reg != '0)
                rev_cnt_next = rev_cnt_reg - COUNT_WIDTH'(1);
        end

        if (is_cmd && word.set_light)
            light_next = word.light_value;
        if (light_btn)
            light_next = !light_reg;

        if (is_cmd && word.set_direction && !fan_reg && (rev_cnt_reg == '0))
            direction_next = word.direction_up;

        if (speed_req_ok && (speed_req_val != SPEED_NOT_SET) && !fan_reg)
            speed_next = speed_req_val;

        // fan last: direction and speed see the fan as it was
        if (fan_req_ok && (fan_req_val != fan_reg) && (fan_cnt_reg == '0))
        begin
            fan_next     = fan_req_val;
            fan_cnt_next = fan_reload;
            if (!fan_req_val)
                rev_cnt_next = rev_reload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg     <= 1'b0;
            fan_reg       <= 1'b0;
            direction_reg <= 1'b0;
            speed_reg     <= SPEED_MIN;
            fan_cnt_reg   <= '0;
            rev_cnt_reg   <= '0;
        end
        else if (step)
        begin
            light_reg     <= light_next;
            fan_reg       <= fan_next;
            direction_reg <= direction_next;
            speed_reg     <= speed_next;
            fan_cnt_reg   <= fan_cnt_next;
            rev_cnt_reg   <= rev_cnt_next;
        end
    end

    always_comb
    begin
        result.light_on        = light_next;
        result.fan_on          = fan_next;
        result.direction_state = direction_next;
        result.speed_now       = speed_next;
        result.light_pin       = light_next;
        result.fan_pin         = fan_next;
        result.direction_pin   = direction_next ^ cfg.direction_invert;
        result.speed_mid_pin   = (speed_next == SPEED_MID);
        result.speed_max_pin   = (speed_next == SPEED_MAX);
        result.fan_locked      = (fan_cnt_next != '0);
        result.reverse_locked  = (rev_cnt_next != '0);
    end

endmodule

// ===== src/fan_light_relay_interlock_top.sv =====
// Channel   Handshake            Word         Carries
// command   cmd_valid/cmd_stall  cmd_word     tick, command or button press
// result    res_valid/res_stall  res_word     state and relay pin levels
// config    APB psel/penable     pwdata       four registers at 4*i
//
// One word per cycle sustained while res_stall is low; res_valid rises once an
// accepted word has passed the command register, then the result register.
// The next-state logic lies between the two registers.
// Reset clears the relay state, both lockout counters and both valid flags.
// A stalled result holds; the command register refills under it and
// cmd_stall rises only when both registers are full.
module fan_light_relay_interlock_top
    import flri_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_word_t             cmd_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_word_t             res_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    cmd_word_t cmd_word_reg;
    logic      cmd_valid_reg;
    res_word_t res_word_reg;
    logic      res_valid_reg;
    res_word_t res_calc;
    logic      advance;

    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    flri_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flri_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg),
        .word   (cmd_word_reg),
        .result (res_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
                cmd_valid_reg <= cmd_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_word_reg <= cmd_word;
        if (advance)
            res_word_reg <= res_calc;
    end

endmodule

// ===== src/flri_checker.sv =====
`include "fan_light_relay_interlock_top_defines.svh"

module flri_checker
    import flri_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_word_t res_word
);

    `FLRI_ASSERT_NOW(a_speed_range, res_valid, res_word.speed_now != SPEED_NOT_SET, "speed out of range")
    `FLRI_ASSERT_NOW(a_speed_pins, res_valid, (res_word.speed_mid_pin == (res_word.speed_now == SPEED_MID)) && (res_word.speed_max_pin == (res_word.speed_now == SPEED_MAX)), "speed pins disagree with speed")
    `FLRI_ASSERT_NOW(a_relay_pins, res_valid, (res_word.light_pin == res_word.light_on) && (res_word.fan_pin == res_word.fan_on), "relay pins disagree with state")
    `FLRI_ASSERT_NEXT(a_result_follows, cmd_valid && !cmd_stall, ##1 res_valid, "no result after accepted word")
    `FLRI_ASSERT_NEXT(a_result_holds, res_valid && res_stall, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind fan_light_relay_interlock_top flri_checker u_flri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);
